// ===== sv/osm_pkg.sv =====
// ----------------------------------------------------------------------------
// osm_pkg: shared types for the order statistic multiset
// Request and response formats, status codes, state encoding and helpers
// that size the reduction tree.
// ----------------------------------------------------------------------------
package osm_pkg;

  localparam int unsigned OSM_CAPACITY = 1024;
  localparam int unsigned OSM_FANIN    = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_ERASE  = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NOP    = 2'd3
  } osm_req_type_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_ABSENT = 2'd3
  } osm_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } osm_state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] item_value;
    logic [10:0]        rank;
  } osm_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [10:0]        entry_count;
  } osm_rsp_t;

  // Control shared by every cell of the row.
  typedef struct packed {
    logic               ins_commit;
    logic               del_commit;
    logic               erase_mode;
    logic               target_en;
    logic signed [31:0] value;
  } osm_cell_ctrl_t;

  function automatic int osm_pow(input int base, input int expo);
    int r;
    r = 1;
    for (int k = 0; k < expo; k++) r = r * base;
    return r;
  endfunction

  // Number of registered levels needed to reduce n leaves.
  function automatic int osm_tree_levels(input int n, input int fan);
    longint cap;
    int     lv;
    cap = fan;
    lv  = 1;
    for (int k = 0; k < 32; k++) begin
      if (cap < n) begin
        cap = cap * fan;
        lv  = lv + 1;
      end
    end
    return lv;
  endfunction

  // Start of level l (1..levels) in the flat node array.
  function automatic int osm_node_offset(input int levels, input int fan, input int l);
    int off;
    off = 0;
    for (int k = 1; k < l; k++) off = off + osm_pow(fan, levels - k);
    return off;
  endfunction

endpackage

// ===== sv/osm_cell.sv =====
// ----------------------------------------------------------------------------
// osm_cell: one slot of the sorted row
// Holds one value, compares it with the request and takes its new value
// from itself, the request or a neighbor when the row inserts or erases.
// ----------------------------------------------------------------------------
module osm_cell #(
  parameter int unsigned CAPACITY = osm_pkg::OSM_CAPACITY,
  localparam int CntW = $clog2(CAPACITY + 1),
  localparam int IdxW = $clog2(CAPACITY)
) (
  input  logic                   clk_i,
  input  osm_pkg::osm_cell_ctrl_t ctrl_i,
  input  logic [IdxW-1:0]        idx_i,
  input  logic [CntW-1:0]        count_i,
  input  logic [CntW-1:0]        target_i,
  input  logic signed [31:0]     left_val_i,
  input  logic                   left_gt_i,
  input  logic                   left_ge_i,
  input  logic signed [31:0]     right_val_i,
  output logic signed [31:0]     val_o,
  output logic                   gt_o,
  output logic                   ge_o,
  output logic                   leaf_hit_o,
  output logic signed [31:0]     leaf_val_o
);
  import osm_pkg::*;

  logic signed [31:0] val_q, val_d;
  logic [CntW-1:0]    idx_ext;
  logic               in_range;
  logic               hit;

  assign idx_ext  = CntW'(idx_i);
  assign in_range = idx_ext < count_i;
  assign gt_o     = in_range && (val_q > ctrl_i.value);
  assign ge_o     = in_range && (val_q >= ctrl_i.value);
  assign val_o    = val_q;

  // For an erase the first cell at or above the value is the only candidate.
  always_comb begin
    if (ctrl_i.erase_mode) begin
      hit = ge_o && !left_ge_i && (val_q == ctrl_i.value);
    end else begin
      hit = ctrl_i.target_en && in_range && (idx_ext == target_i);
    end
  end

  assign leaf_hit_o = hit;
  assign leaf_val_o = hit ? val_q : 32'sd0;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins_commit) begin
      if (left_gt_i) begin
        val_d = left_val_i;
      end else if (gt_o || idx_ext == count_i) begin
        val_d = ctrl_i.value;
      end
    end else if (ctrl_i.del_commit && ge_o) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== sv/osm_or_tree.sv =====
// ----------------------------------------------------------------------------
// osm_or_tree: registered reduction of the cell row
// Collects the single flagged cell and its value through a few registered
// levels of wide OR gates.
// ----------------------------------------------------------------------------
module osm_or_tree #(
  parameter int unsigned LEAVES = osm_pkg::OSM_CAPACITY,
  parameter int unsigned FANIN  = osm_pkg::OSM_FANIN,
  localparam int Levels = osm_pkg::osm_tree_levels(LEAVES, FANIN),
  localparam int Padded = osm_pkg::osm_pow(FANIN, Levels),
  localparam int Nodes  = osm_pkg::osm_node_offset(Levels, FANIN, Levels + 1)
) (
  input  logic               clk_i,
  input  logic               leaf_hit_i [LEAVES],
  input  logic signed [31:0] leaf_val_i [LEAVES],
  output logic               root_hit_o,
  output logic signed [31:0] root_val_o
);
  import osm_pkg::*;

  logic               pad_hit [Padded];
  logic signed [31:0] pad_val [Padded];
  logic               node_hit_q [Nodes];
  logic signed [31:0] node_val_q [Nodes];

  for (genvar i = 0; i < Padded; i++) begin : g_pad
    if (i < LEAVES) begin : g_leaf
      assign pad_hit[i] = leaf_hit_i[i];
      assign pad_val[i] = leaf_val_i[i];
    end else begin : g_zero
      assign pad_hit[i] = 1'b0;
      assign pad_val[i] = 32'sd0;
    end
  end

  for (genvar l = 1; l <= Levels; l++) begin : g_level
    localparam int Count = osm_pow(FANIN, Levels - l);
    localparam int Off   = osm_node_offset(Levels, FANIN, l);
    localparam int Prev  = osm_node_offset(Levels, FANIN, l - 1);
    for (genvar j = 0; j < Count; j++) begin : g_node
      logic               hit_d;
      logic signed [31:0] val_d;
      if (l == 1) begin : g_from_leaf
        always_comb begin
          hit_d = 1'b0;
          val_d = 32'sd0;
          for (int k = 0; k < FANIN; k++) begin
            hit_d = hit_d | pad_hit[j*FANIN + k];
            val_d = val_d | pad_val[j*FANIN + k];
          end
        end
      end else begin : g_from_node
        always_comb begin
          hit_d = 1'b0;
          val_d = 32'sd0;
          for (int k = 0; k < FANIN; k++) begin
            hit_d = hit_d | node_hit_q[Prev + j*FANIN + k];
            val_d = val_d | node_val_q[Prev + j*FANIN + k];
          end
        end
      end
      always_ff @(posedge clk_i) begin
        node_hit_q[Off + j] <= hit_d;
        node_val_q[Off + j] <= val_d;
      end
    end
  end

  assign root_hit_o = node_hit_q[Nodes-1];
  assign root_val_o = node_val_q[Nodes-1];

endmodule

// ===== sv/order_statistic_multiset.sv =====
// ----------------------------------------------------------------------------
// order_statistic_multiset: sorted multiset with rank-th largest lookup
// Insert and unused codes answer from the scan state; erase and query also wait
// for the L registered levels of the 32-way OR tree (L = 2 at 1024 entries)
// and answer from the finish state. A new item is accepted only when idle, so
// one item is in flight at a time. Results cannot be stalled.
// Reset clears the count and control state only; the cell row needs no clearing pass.
// ----------------------------------------------------------------------------
module order_statistic_multiset #(
  parameter int unsigned CAPACITY = osm_pkg::OSM_CAPACITY
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  osm_pkg::osm_req_t req_i,
  output logic              busy_o,
  output logic              rsp_valid_o,
  output osm_pkg::osm_rsp_t rsp_o
);
  import osm_pkg::*;

  localparam int CntW   = $clog2(CAPACITY + 1);
  localparam int IdxW   = $clog2(CAPACITY);
  localparam int RankW  = (CntW > 11) ? CntW : 11;
  localparam int Levels = osm_tree_levels(CAPACITY, OSM_FANIN);
  localparam int WaitW  = $clog2(Levels + 1);

  osm_state_e      state_q, state_d;
  osm_req_t        req_q;
  logic [CntW-1:0] count_q, count_d;
  logic [WaitW-1:0] wait_q, wait_d;
  osm_rsp_t        rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  logic            full;
  logic            rank_ok;
  logic [CntW-1:0] target;
  logic            ins_commit, del_commit;
  osm_cell_ctrl_t  ctrl;

  logic signed [31:0] cell_val  [CAPACITY];
  logic               cell_gt   [CAPACITY];
  logic               cell_ge   [CAPACITY];
  logic               leaf_hit  [CAPACITY];
  logic signed [31:0] leaf_val  [CAPACITY];
  logic               root_hit;
  logic signed [31:0] root_val;

  assign full    = count_q >= CntW'(CAPACITY);
  assign rank_ok = (req_q.rank != 11'd0) && (RankW'(req_q.rank) <= RankW'(count_q));
  assign target  = count_q - CntW'(req_q.rank);

  assign ctrl.ins_commit = ins_commit;
  assign ctrl.del_commit = del_commit;
  assign ctrl.erase_mode = req_q.req_type == REQ_ERASE;
  assign ctrl.target_en  = (req_q.req_type == REQ_QUERY) && rank_ok;
  assign ctrl.value      = req_q.item_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_val, right_val;
    logic               left_gt, left_ge;
    if (i == 0) begin : g_first
      assign left_val = 32'sd0;
      assign left_gt  = 1'b0;
      assign left_ge  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
      assign left_ge  = cell_ge[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_right
      assign right_val = cell_val[i+1];
    end
    osm_cell #(.CAPACITY(CAPACITY)) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .idx_i      (IdxW'(i)),
      .count_i    (count_q),
      .target_i   (target),
      .left_val_i (left_val),
      .left_gt_i  (left_gt),
      .left_ge_i  (left_ge),
      .right_val_i(right_val),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i]),
      .ge_o       (cell_ge[i]),
      .leaf_hit_o (leaf_hit[i]),
      .leaf_val_o (leaf_val[i])
    );
  end

  osm_or_tree #(.LEAVES(CAPACITY), .FANIN(OSM_FANIN)) u_tree (
    .clk_i     (clk_i),
    .leaf_hit_i(leaf_hit),
    .leaf_val_i(leaf_val),
    .root_hit_o(root_hit),
    .root_val_o(root_val)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (req_q.req_type == REQ_INSERT || req_q.req_type == REQ_NOP) begin
          state_d = S_IDLE;
        end else if (wait_q == WaitW'(Levels - 1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    busy_o      = state_q != S_IDLE;
    wait_d      = '0;
    count_d     = count_q;
    ins_commit  = 1'b0;
    del_commit  = 1'b0;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    unique case (state_q)
      S_IDLE: ;
      S_SCAN: begin
        wait_d = wait_q + WaitW'(1);
        if (req_q.req_type == REQ_INSERT) begin
          ins_commit         = !full;
          count_d            = full ? count_q : count_q + CntW'(1);
          rsp_valid_d        = 1'b1;
          rsp_d.result_value = 32'sd0;
          rsp_d.status       = full ? ST_FULL : ST_OK;
        end else if (req_q.req_type == REQ_NOP) begin
          rsp_valid_d        = 1'b1;
          rsp_d.result_value = 32'sd0;
          rsp_d.status       = ST_OK;
        end
      end
      S_FINISH: begin
        rsp_valid_d = 1'b1;
        if (req_q.req_type == REQ_ERASE) begin
          del_commit         = root_hit;
          count_d            = root_hit ? count_q - CntW'(1) : count_q;
          rsp_d.result_value = 32'sd0;
          rsp_d.status       = root_hit ? ST_OK : ST_ABSENT;
        end else begin
          rsp_d.result_value = rank_ok ? root_val : 32'sd0;
          rsp_d.status       = rank_ok ? ST_OK : ST_RANGE;
        end
      end
      default: ;
    endcase
    rsp_d.entry_count = 11'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      wait_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wait_q      <= wait_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (start_i && !busy_o) req_q <= req_i;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ins_commit && del_commit))
    else $error("insert and erase committed together");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == ST_FULL) |-> (count_q == CntW'(CAPACITY)))
    else $error("full status with room left");

  a_count_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> rsp_valid_o)
    else $error("count changed without a result");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_SCAN))
    else $error("accepted item did not start a scan");

endmodule

// ===== verif/tb_order_statistic_multiset.sv =====
// ----------------------------------------------------------------------------
// tb_order_statistic_multiset: self-checking bench for the sorted multiset
// A mirror of the multiset predicts each response from the accepted items.
// Directed tests cover the empty store, extreme and duplicate values, every
// flag and the unused code. Random tests mix requests, fill the store to
// capacity and then send mostly erases and queries, with random gaps on the request side.
// ----------------------------------------------------------------------------
module tb_order_statistic_multiset;
  import osm_pkg::*;

  localparam int unsigned DEPTH = OSM_CAPACITY;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  osm_req_t req_i;
  logic     busy_o;
  logic     rsp_valid_o;
  osm_rsp_t rsp_o;

  order_statistic_multiset #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  // Mirror of the multiset, kept in ascending order.
  logic signed [31:0] mirror_store [DEPTH];
  int unsigned        mirror_count;
  int unsigned        peak_count;

  osm_rsp_t    pending_rsp_q[$];
  int unsigned error_count;
  int unsigned checked_count;
  int unsigned sent_by_kind [4];
  int unsigned seen_by_status [4];
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("timeout with %0d responses outstanding", pending_rsp_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Applies one request to the mirror and returns the response it must give.
  function automatic osm_rsp_t multiset_apply(input osm_req_t r);
    osm_rsp_t    rsp;
    int unsigned pos;
    bit          found;
    rsp = '0;
    case (osm_req_type_e'(r.req_type))
      REQ_INSERT: begin
        if (mirror_count >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          pos = mirror_count;
          // Equal values stay below the new one.
          while (pos > 0 && mirror_store[pos-1] > r.item_value) begin
            mirror_store[pos] = mirror_store[pos-1];
            pos--;
          end
          mirror_store[pos] = r.item_value;
          mirror_count++;
        end
      end
      REQ_ERASE: begin
        found = 1'b0;
        pos   = 0;
        for (int unsigned i = 0; i < mirror_count; i++) begin
          if (!found && mirror_store[i] == r.item_value) begin
            found = 1'b1;
            pos   = i;
          end
        end
        if (!found) begin
          rsp.status = ST_ABSENT;
        end else begin
          for (int unsigned i = pos; i + 1 < mirror_count; i++)
            mirror_store[i] = mirror_store[i+1];
          mirror_count--;
        end
      end
      REQ_QUERY: begin
        if (r.rank == 0 || r.rank > mirror_count) rsp.status = ST_RANGE;
        else rsp.result_value = mirror_store[mirror_count - r.rank];
      end
      default: ;
    endcase
    rsp.entry_count = mirror_count[10:0];
    if (mirror_count > peak_count) peak_count = mirror_count;
    return rsp;
  endfunction

  // Presents one item, holds it until accepted and records its response.
  task automatic send_item(input osm_req_type_e kind, input logic signed [31:0] value,
                           input logic [10:0] rk);
    osm_req_t r;
    r.req_type   = kind;
    r.item_value = value;
    r.rank       = rk;
    if (idle_on) begin
      while ($urandom_range(99) < 19) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    pending_rsp_q.push_back(multiset_apply(r));
    sent_by_kind[kind]++;
  endtask

  always @(posedge clk_i) begin : check_rsp
    osm_rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (pending_rsp_q.size() == 0) begin
        flag_error($sformatf("response with none expected: value %0d status %0d count %0d",
                             rsp_o.result_value, rsp_o.status, rsp_o.entry_count));
      end else begin
        want = pending_rsp_q.pop_front();
        checked_count++;
        seen_by_status[want.status]++;
        if (rsp_o.result_value !== want.result_value)
          flag_error($sformatf("result_value expected %0d got %0d",
                               want.result_value, rsp_o.result_value));
        if (rsp_o.status !== want.status)
          flag_error($sformatf("status expected %0d got %0d", want.status, rsp_o.status));
        if (rsp_o.entry_count !== want.entry_count)
          flag_error($sformatf("entry_count expected %0d got %0d",
                               want.entry_count, rsp_o.entry_count));
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3, 4: return int'($urandom_range(16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Mostly values that are present, so erases reach the removal path.
  function automatic logic signed [31:0] pick_erase_value();
    if (mirror_count > 0 && $urandom_range(99) < 70)
      return mirror_store[$urandom_range(mirror_count - 1)];
    return pick_value();
  endfunction

  function automatic logic [10:0] pick_rank();
    int unsigned roll;
    roll = $urandom_range(99);
    if (mirror_count > 0 && roll < 70) return 11'($urandom_range(mirror_count, 1));
    if (roll < 80) return '0;
    if (roll < 90) return 11'(mirror_count + 1);
    return 11'($urandom_range(2047));
  endfunction

  task automatic random_item(input int unsigned ins_pct);
    int unsigned roll;
    int unsigned erase_lim;
    int unsigned query_lim;
    roll      = $urandom_range(99);
    erase_lim = ins_pct + (100 - ins_pct) * 45 / 100;
    query_lim = erase_lim + (100 - ins_pct) * 45 / 100;
    if (roll < ins_pct)
      send_item(REQ_INSERT, pick_value(), 11'($urandom_range(2047)));
    else if (roll < erase_lim)
      send_item(REQ_ERASE, pick_erase_value(), 11'($urandom_range(2047)));
    else if (roll < query_lim)
      send_item(REQ_QUERY, $urandom, pick_rank());
    else
      send_item(REQ_NOP, $urandom, 11'($urandom_range(2047)));
  endtask

  task automatic test_empty_store();
    send_item(REQ_QUERY, 32'sd0, 11'd1);
    send_item(REQ_QUERY, 32'sd0, 11'd0);
    send_item(REQ_ERASE, 32'sd0, 11'd0);
    send_item(REQ_NOP, VAL_MAX, 11'd2047);
  endtask

  task automatic test_insert_order();
    send_item(REQ_INSERT, VAL_MIN, 11'd0);
    send_item(REQ_INSERT, VAL_MAX, 11'd2047);
    send_item(REQ_INSERT, 32'sd0, 11'd0);
    send_item(REQ_INSERT, -32'sd1, 11'd0);
    repeat (3) send_item(REQ_INSERT, 32'sd5, 11'd0);
  endtask

  task automatic test_query_ranks();
    send_item(REQ_QUERY, 32'sd0, 11'd1);
    send_item(REQ_QUERY, 32'sd0, 11'd7);
    send_item(REQ_QUERY, 32'sd0, 11'd8);
    send_item(REQ_QUERY, 32'sd0, 11'd0);
    send_item(REQ_QUERY, 32'sd0, 11'd2047);
  endtask

  task automatic test_erase_cases();
    send_item(REQ_ERASE, 32'sd5, 11'd0);
    send_item(REQ_QUERY, 32'sd0, 11'd2);
    send_item(REQ_ERASE, 32'sd42, 11'd0);
    send_item(REQ_ERASE, VAL_MIN, 11'd0);
    send_item(REQ_NOP, $urandom, 11'($urandom_range(2047)));
  endtask

  // The middle stretch runs with no gaps at all.
  task automatic test_random_mix(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      idle_on = !(i >= n / 3 && i < 2 * n / 3);
      random_item(45);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_fill_to_capacity();
    while (mirror_count < DEPTH) random_item(94);
  endtask

  task automatic test_full_store();
    repeat (8) send_item(REQ_INSERT, pick_value(), 11'($urandom_range(2047)));
    send_item(REQ_QUERY, 32'sd0, 11'(DEPTH));
    send_item(REQ_QUERY, 32'sd0, 11'(DEPTH + 1));
    send_item(REQ_QUERY, 32'sd0, 11'd1);
    send_item(REQ_QUERY, 32'sd0, 11'd2047);
    send_item(REQ_QUERY, 32'sd0, 11'd0);
    send_item(REQ_ERASE, pick_erase_value(), 11'd0);
    send_item(REQ_INSERT, pick_value(), 11'd0);
    send_item(REQ_INSERT, pick_value(), 11'd0);
    repeat (25) random_item(50);
  endtask

  task automatic test_drain(input int unsigned n);
    repeat (n) random_item(10);
  endtask

  initial begin
    start_i       <= 1'b0;
    req_i         <= '0;
    rst_ni        <= 1'b0;
    idle_on       = 1'b1;
    mirror_count  = 0;
    peak_count    = 0;
    error_count   = 0;
    checked_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store();
    test_insert_order();
    test_query_ranks();
    test_erase_cases();
    test_random_mix(150);
    test_fill_to_capacity();
    test_full_store();
    test_drain(40);

    start_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("sent %0d inserts, %0d erases, %0d queries, %0d unused codes; %0d responses checked",
             sent_by_kind[REQ_INSERT], sent_by_kind[REQ_ERASE], sent_by_kind[REQ_QUERY],
             sent_by_kind[REQ_NOP], checked_count);
    $display("flags: %0d full, %0d rank out of range, %0d absent; peak occupancy %0d of %0d",
             seen_by_status[ST_FULL], seen_by_status[ST_RANGE], seen_by_status[ST_ABSENT],
             peak_count, DEPTH);
    if (error_count == 0 && pending_rsp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
